[sv/sha256_pkg.sv]
`default_nettype none

package sha256_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned HASH_N    = 8;
   localparam int unsigned SCHED_N   = 16;
   localparam int unsigned ROUND_N   = 64;
   localparam int unsigned ROUND_W   = $clog2(ROUND_N);
   localparam int unsigned COUNT_W   = $clog2(SCHED_N);
   localparam int unsigned INDEX_W   = $clog2(HASH_N);

   localparam logic [COUNT_W-1:0] LAST_WORD  = COUNT_W'(SCHED_N - 1);
   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_N - 1);
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(HASH_N - 1);

   // element [0] is H0
   localparam logic [HASH_N-1:0][WORD_W-1:0] INIT_HASH = {
      32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
      32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
   };

   localparam logic [WORD_W-1:0] ROUND_K [ROUND_N] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_DIGEST
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] message_word;
      logic              first_word;
      logic              final_block;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  digest_word;
      logic [INDEX_W-1:0] digest_index;
      logic               digest_last;
   } rsp_type;

   typedef struct packed {
      logic               shift_word;
      logic               load_vars;
      logic               round_en;
      logic [ROUND_W-1:0] round_idx;
   } round_ctrl_type;

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

[sv/sha256_compression_core.sv]
// channel  | ports                            | carries
// ---------+----------------------------------+----------------------------------
// request  | req_valid, req_stall, req_payload | message word, first, final flags
// response | rsp_valid, rsp_stall, rsp_payload | digest word, index, last flag
//
// Words are taken while req_stall is low; the sixteenth word of a block starts
// the rounds on the shared round unit, followed by a hash update state. A final
// block then sends 8 digest beats, one per unstalled cycle. req_stall is high
// from the sixteenth word until the hash update is done, or until the digest is
// out for a final block. Reset loads the initial hash and clears the word count.
`default_nettype none

module sha256_compression_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire sha256_pkg::req_type req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output sha256_pkg::rsp_type      rsp_payload
);

   sha256_pkg::state_type state_ff, state_in;

   logic [sha256_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [sha256_pkg::ROUND_W-1:0] round_ff, round_in;
   logic [sha256_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic                           final_ff, final_in;
   logic [sha256_pkg::HASH_N-1:0][sha256_pkg::WORD_W-1:0] hash_ff, hash_in;
   logic [sha256_pkg::HASH_N-1:0][sha256_pkg::WORD_W-1:0] vars;

   logic                           req_accept;
   logic [sha256_pkg::COUNT_W-1:0] count_eff;
   logic                           block_done;
   sha256_pkg::round_ctrl_type     ctrl;

   assign req_accept = req_valid && !req_stall;
   assign count_eff  = req_payload.first_word ? '0 : count_ff;
   assign block_done = req_accept && (count_eff == sha256_pkg::LAST_WORD);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (block_done) state_in = sha256_pkg::ST_ROUND;
         end
         sha256_pkg::ST_ROUND: begin
            if (round_ff == sha256_pkg::LAST_ROUND) state_in = sha256_pkg::ST_UPDATE;
         end
         sha256_pkg::ST_UPDATE: begin
            state_in = final_ff ? sha256_pkg::ST_DIGEST : sha256_pkg::ST_IDLE;
         end
         sha256_pkg::ST_DIGEST: begin
            if (!rsp_stall && (idx_ff == sha256_pkg::LAST_INDEX)) state_in = sha256_pkg::ST_IDLE;
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = (state_ff != sha256_pkg::ST_IDLE);
      rsp_valid      = (state_ff == sha256_pkg::ST_DIGEST);
      ctrl.shift_word = req_accept;
      ctrl.load_vars  = block_done;
      ctrl.round_en   = (state_ff == sha256_pkg::ST_ROUND);
      ctrl.round_idx  = round_ff;
   end

   always_comb begin
      count_in = count_ff;
      round_in = '0;
      idx_in   = idx_ff;
      final_in = final_ff;
      hash_in  = hash_ff;
      if (req_accept) begin
         count_in = block_done ? '0 : count_eff + sha256_pkg::COUNT_W'(1);
         if (req_payload.first_word) hash_in = sha256_pkg::INIT_HASH;
      end
      if (block_done) final_in = req_payload.final_block;
      if (state_ff == sha256_pkg::ST_ROUND) round_in = round_ff + sha256_pkg::ROUND_W'(1);
      if (state_ff == sha256_pkg::ST_UPDATE) begin
         idx_in = '0;
         for (int i = 0; i < sha256_pkg::HASH_N; i++) begin
            hash_in[i] = hash_ff[i] + vars[i];
         end
      end
      if (rsp_valid && !rsp_stall) idx_in = idx_ff + sha256_pkg::INDEX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         count_ff <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         final_ff <= 1'b0;
         hash_ff  <= sha256_pkg::INIT_HASH;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         final_ff <= final_in;
         hash_ff  <= hash_in;
      end
   end

   sha256_round u_round (
      .clock (clock),
      .ctrl  (ctrl),
      .word  (req_payload.message_word),
      .hash  (hash_ff),
      .vars  (vars)
   );

   always_comb begin
      rsp_payload.digest_word  = hash_ff[idx_ff];
      rsp_payload.digest_index = idx_ff;
      rsp_payload.digest_last  = (idx_ff == sha256_pkg::LAST_INDEX);
   end

endmodule

`default_nettype wire

[sv/sha256_round.sv]
`default_nettype none

module sha256_round (
   input  wire logic                                                 clock,
   input  wire sha256_pkg::round_ctrl_type                           ctrl,
   input  wire logic [sha256_pkg::WORD_W-1:0]                        word,
   input  wire logic [sha256_pkg::HASH_N-1:0][sha256_pkg::WORD_W-1:0] hash,
   output logic      [sha256_pkg::HASH_N-1:0][sha256_pkg::WORD_W-1:0] vars
);

   // sched_ff[0] is the oldest word of the 16-word window
   logic [sha256_pkg::SCHED_N-1:0][sha256_pkg::WORD_W-1:0] sched_ff, sched_in;
   logic [sha256_pkg::HASH_N-1:0][sha256_pkg::WORD_W-1:0]  vars_ff, vars_in;

   logic [sha256_pkg::WORD_W-1:0] expand;
   logic [sha256_pkg::WORD_W-1:0] wt;
   logic [sha256_pkg::WORD_W-1:0] ch;
   logic [sha256_pkg::WORD_W-1:0] maj;
   logic [sha256_pkg::WORD_W-1:0] t1;
   logic [sha256_pkg::WORD_W-1:0] t2;

   always_comb begin
      expand = sched_ff[0] + sha256_pkg::small_sigma0(sched_ff[1]) + sched_ff[9]
             + sha256_pkg::small_sigma1(sched_ff[14]);
      wt  = (ctrl.round_idx[sha256_pkg::ROUND_W-1:sha256_pkg::COUNT_W] == '0)
            ? sched_ff[0] : expand;
      ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]);
      t1  = vars_ff[7] + sha256_pkg::big_sigma1(vars_ff[4]) + ch
          + sha256_pkg::ROUND_K[ctrl.round_idx] + wt;
      t2  = sha256_pkg::big_sigma0(vars_ff[0]) + maj;
   end

   always_comb begin
      sched_in = sched_ff;
      vars_in  = vars_ff;
      if (ctrl.shift_word) begin
         sched_in = {word, sched_ff[sha256_pkg::SCHED_N-1:1]};
      end else if (ctrl.round_en) begin
         sched_in = {wt, sched_ff[sha256_pkg::SCHED_N-1:1]};
      end
      if (ctrl.load_vars) begin
         vars_in = hash;
      end else if (ctrl.round_en) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      vars_ff  <= vars_in;
   end

   assign vars = vars_ff;

endmodule

`default_nettype wire

[sv/sha256_checker.sv]
`default_nettype none

module sha256_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire sha256_pkg::rsp_type rsp_payload
);

   // a stalled digest beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("digest beat changed under stall");

   // no word is taken while the digest is going out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken during digest");

   // digest beats come in index order without gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.digest_last |=>
         rsp_valid &&
         (rsp_payload.digest_index ==
          sha256_pkg::INDEX_W'($past(rsp_payload.digest_index) + 1'b1)))
      else $error("digest index out of order");

   // last flag marks exactly the top index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.digest_last ==
                     (rsp_payload.digest_index == sha256_pkg::LAST_INDEX)))
      else $error("digest last flag mismatch");

   // the first digest beat after a stretch of idle is index zero
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_payload.digest_index == '0))
      else $error("digest did not start at index zero");

endmodule

bind sha256_compression_core sha256_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
